// ===== hw/rtl/top_k_score_table_core_assert.svh =====
// Assertion macros used by the checker file of top_k_score_table_core.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef TOP_K_SCORE_TABLE_CORE_ASSERT_SVH
`define TOP_K_SCORE_TABLE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TKST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("top_k_score_table_core: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TKST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("top_k_score_table_core: next-cycle check failed");

`endif

// ===== hw/rtl/tkst_pkg.sv =====
// Shared types, field widths and the label cleaning function of the top-K score table.
// No dependencies.
package tkst_pkg;

  localparam int unsigned ModeW    = 2;
  localparam int unsigned TableW   = 8;
  localparam int unsigned RankFldW = 4;
  localparam int unsigned ScoreW   = 32;
  localparam int unsigned LabelW   = 48;
  localparam int unsigned PlacedW  = 3;
  localparam int unsigned TotalW   = 4;
  localparam int unsigned CfgW     = 6;
  localparam int unsigned LabelBytes = LabelW / 8;

  localparam logic [CfgW-1:0] ActiveTablesRst = 6'd32;

  localparam logic [7:0] ChA    = 8'h41;
  localparam logic [7:0] ChZ    = 8'h5A;
  localparam logic [7:0] Ch0    = 8'h30;
  localparam logic [7:0] Ch9    = 8'h39;
  localparam logic [7:0] ChDash = 8'h2D;
  localparam logic [7:0] ChNul  = 8'h00;

  typedef enum logic [ModeW-1:0] {
    MODE_ADD     = 2'd0,
    MODE_READ    = 2'd1,
    MODE_QUALIFY = 2'd2,
    MODE_IGNORE  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [LabelW-1:0] label;
  } entry_t;

  // Keep A-Z and 0-9, map anything else to '-', stop at the first NUL or after chars bytes.
  function automatic logic [LabelW-1:0] clean_label(input logic [LabelW-1:0] raw,
                                                    input int unsigned chars);
    logic [LabelW-1:0] res;
    logic              ended;
    logic [7:0]        c;
    res   = '0;
    ended = 1'b0;
    for (int unsigned i = 0; i < LabelBytes; i++) begin
      c = raw[8*i +: 8];
      if (c == ChNul) begin
        ended = 1'b1;
      end
      if (!ended && (i < chars)) begin
        if ((c >= ChA && c <= ChZ) || (c >= Ch0 && c <= Ch9)) begin
          res[8*i +: 8] = c;
        end else begin
          res[8*i +: 8] = ChDash;
        end
      end
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/tkst_if.sv =====
// Valid/ready channel interfaces for the request and result transactions.
// Depends on tkst_pkg.
interface tkst_in_if import tkst_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ModeW-1:0]    mode;
  logic [TableW-1:0]   table_index;
  logic [RankFldW-1:0] read_rank;
  logic [ScoreW-1:0]   new_score;
  logic [LabelW-1:0]   new_label;

  modport source (output valid, mode, table_index, read_rank, new_score, new_label,
                  input ready);
  modport sink   (input valid, mode, table_index, read_rank, new_score, new_label,
                  output ready);
endinterface

interface tkst_out_if import tkst_pkg::*;;
  logic               valid;
  logic               ready;
  logic               status;
  logic [PlacedW-1:0] placed_rank;
  logic [ScoreW-1:0]  entry_score;
  logic [LabelW-1:0]  entry_label;
  logic [TotalW-1:0]  entry_total;

  modport source (output valid, status, placed_rank, entry_score, entry_label, entry_total,
                  input ready);
  modport sink   (input valid, status, placed_rank, entry_score, entry_label, entry_total,
                  output ready);
endinterface

// ===== hw/rtl/tkst_entry_ram.sv =====
// Entry store: one write port, one read port with registered read data.
// Depends on tkst_pkg (entry_t).
module tkst_entry_ram import tkst_pkg::*; #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/top_k_score_table_core.sv =====
// Top-K score table core: sequencer around the entry store; depends on tkst_pkg,
// tkst_if and tkst_entry_ram.
//
// Keeps one best-first list of up to LIST_DEPTH (score, label) entries for each of
// TABLES tables, all lists in one single-port-read/single-port-write entry RAM at
// slot table*LIST_DEPTH + rank. One request transaction is in flight at a time:
// in_i.ready is high only while the core is idle, and a result stays on out_o
// until taken. An add walks the table's stored entries best first through the
// one RAM read port, one entry per cycle; the first entry it beats receives the
// new entry and every later entry moves down one rank on the fly (read of rank
// r+1 overlaps the write of rank r), the tail write lands on the former count
// when the list was not full, and on a full list the lowest entry falls off.
// From acceptance, an add passes ST_START, ST_SCAN once for each stored entry, and
// ST_TAIL when the list was not full (an empty list goes from ST_START to ST_TAIL);
// read and qualify pass ST_START and then ST_FETCH only when the RAM must be
// consulted; out-of-range tables go from ST_START straight to ST_OUT. After the
// result is taken the core passes ST_IDLE before it accepts a new request. Labels
// are cleaned on the way in (A-Z and 0-9 kept, other bytes become '-', a NUL ends
// the name). active_tables (reset 32) limits the usable tables to
// min(active_tables, TABLES); write it only while idle. Per-table counts live in
// flops and clear at reset; the RAM has no reset and no data past a count is used.
module top_k_score_table_core import tkst_pkg::*; #(
  parameter int unsigned TABLES      = 32,
  parameter int unsigned LIST_DEPTH  = 8,
  parameter int unsigned LABEL_CHARS = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tkst_in_if.sink         in_i,
  tkst_out_if.source      out_o,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned Slots = TABLES * LIST_DEPTH;
  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned TblW  = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int unsigned RankW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(LIST_DEPTH + 1);

  localparam logic [CntW-1:0]  FullCnt   = CntW'(LIST_DEPTH);
  localparam logic [RankW-1:0] LastRank  = RankW'(LIST_DEPTH - 1);
  localparam logic [TableW:0]  TablesLim = (TableW + 1)'(TABLES);

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for a request transaction
    ST_START,  // range check, count lookup, first RAM read
    ST_SCAN,   // add: compare and shift one stored entry per cycle
    ST_TAIL,   // add: write the last entry at the old count
    ST_FETCH,  // read/qualify: RAM data is back
    ST_OUT     // result held until taken
  } state_e;

  state_e              state_q;
  mode_e               mode_q;
  logic [TableW-1:0]   tbl_q;
  logic [RankFldW-1:0] rank_q;
  logic [ScoreW-1:0]   score_q;
  logic [LabelW-1:0]   label_q;     // already cleaned
  logic [CfgW-1:0]     act_q;
  logic [CntW-1:0]     fill_q [TABLES];
  logic [CntW-1:0]     n_q;         // count of the table when the item started
  logic [RankW-1:0]    idx_q;       // rank whose RAM data is on rdata in ST_SCAN
  logic                ins_q;       // new entry already written during the scan
  logic [RankW-1:0]    placed_q;
  entry_t              carry_q;     // entry displaced by the previous write

  logic                res_status_q;
  logic [PlacedW-1:0]  res_placed_q;
  logic [ScoreW-1:0]   res_score_q;
  logic [LabelW-1:0]   res_label_q;
  logic [TotalW-1:0]   res_total_q;

  // RAM port signals
  logic                ram_we;
  logic [SlotW-1:0]    ram_waddr;
  entry_t              ram_wdata;
  logic [SlotW-1:0]    ram_raddr;
  entry_t              ram_rdata;

  logic [TblW-1:0]     tbl_idx;
  logic                in_range;
  logic [CntW-1:0]     cur_cnt;
  logic [SlotW-1:0]    base;
  logic                gt;
  logic [CntW-1:0]     idx_next;
  logic                scan_done;
  logic                beats;
  entry_t              new_entry;

  assign tbl_idx   = tbl_q[TblW-1:0];
  // Table usable when below both the parameter and the configured count.
  assign in_range  = ({1'b0, tbl_q} < TablesLim) && ({2'b00, act_q} > tbl_q);
  assign cur_cnt   = fill_q[tbl_idx];
  assign base      = SlotW'(tbl_idx) * SlotW'(LIST_DEPTH);
  assign gt        = score_q > ram_rdata.score;
  assign idx_next  = CntW'(idx_q) + CntW'(1);
  assign scan_done = idx_next >= n_q;
  assign beats     = ins_q || gt;
  assign new_entry = '{score: score_q, label: label_q};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = base;
    ram_wdata = ins_q ? carry_q : new_entry;
    ram_raddr = base;
    case (state_q)
      ST_START: begin
        case (mode_q)
          MODE_READ:    ram_raddr = base + SlotW'(rank_q[RankW-1:0]);
          MODE_QUALIFY: ram_raddr = base + SlotW'(LastRank);
          default:      ram_raddr = base;   // add starts at the best entry
        endcase
      end
      ST_SCAN: begin
        ram_raddr = base + SlotW'(RankW'(idx_next));
        ram_we    = beats;
        ram_waddr = base + SlotW'(idx_q);
      end
      ST_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = base + SlotW'(RankW'(n_q));
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tkst_entry_ram #(
    .Depth (Slots),
    .AddrW (SlotW)
  ) u_tkst_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      act_q   <= ActiveTablesRst;
      fill_q  <= '{default: '0};
      ins_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        act_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            mode_q  <= mode_e'(in_i.mode);
            tbl_q   <= in_i.table_index;
            rank_q  <= in_i.read_rank;
            score_q <= in_i.new_score;
            label_q <= clean_label(in_i.new_label, LABEL_CHARS);
            state_q <= ST_START;
          end
        end
        ST_START: begin
          n_q          <= cur_cnt;
          idx_q        <= '0;
          ins_q        <= 1'b0;
          placed_q     <= '0;
          res_status_q <= 1'b1;
          res_placed_q <= '0;
          res_score_q  <= '0;
          res_label_q  <= '0;
          res_total_q  <= '0;
          state_q      <= ST_OUT;
          if (in_range) begin
            res_total_q <= TotalW'(cur_cnt);
            case (mode_q)
              MODE_ADD: begin
                state_q <= (cur_cnt == '0) ? ST_TAIL : ST_SCAN;
              end
              MODE_READ: begin
                if (rank_q < RankFldW'(cur_cnt)) begin
                  state_q <= ST_FETCH;
                end
              end
              MODE_QUALIFY: begin
                if (cur_cnt < FullCnt) begin
                  res_status_q <= 1'b0;
                end else begin
                  state_q <= ST_FETCH;
                end
              end
              default: begin
                state_q <= ST_OUT;   // ignored mode: rejected
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (!ins_q && gt) begin
            placed_q <= idx_q;
          end
          if (beats) begin
            ins_q   <= 1'b1;
            carry_q <= ram_rdata;
          end
          idx_q <= RankW'(idx_next);
          if (scan_done) begin
            if (n_q < FullCnt) begin
              state_q <= ST_TAIL;
            end else begin
              // full list: the lowest entry (the last carry, or the new entry if it beat none) is dropped
              res_status_q <= !beats;
              if (ins_q) begin
                res_placed_q <= PlacedW'(placed_q);
              end else if (gt) begin
                res_placed_q <= PlacedW'(idx_q);
              end
              state_q <= ST_OUT;
            end
          end
        end
        ST_TAIL: begin
          fill_q[tbl_idx] <= n_q + CntW'(1);
          res_status_q    <= 1'b0;
          res_placed_q    <= ins_q ? PlacedW'(placed_q) : PlacedW'(n_q);
          res_total_q     <= TotalW'(n_q + CntW'(1));
          state_q         <= ST_OUT;
        end
        ST_FETCH: begin
          if (mode_q == MODE_READ) begin
            res_status_q <= 1'b0;
            res_score_q  <= ram_rdata.score;
            res_label_q  <= ram_rdata.label;
          end else begin
            res_status_q <= !gt;
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = (state_q == ST_OUT);
  assign out_o.status      = res_status_q;
  assign out_o.placed_rank = res_placed_q;
  assign out_o.entry_score = res_score_q;
  assign out_o.entry_label = res_label_q;
  assign out_o.entry_total = res_total_q;

endmodule

// ===== hw/rtl/tkst_checker.sv =====
// Port-level checks for top_k_score_table_core, attached by bind.
// Depends on tkst_pkg and top_k_score_table_core_assert.svh.
`include "top_k_score_table_core_assert.svh"

module tkst_checker import tkst_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               out_status_i,
  input logic [PlacedW-1:0] out_placed_i,
  input logic [ScoreW-1:0]  out_score_i,
  input logic [LabelW-1:0]  out_label_i,
  input logic [TotalW-1:0]  out_total_i
);

  // one transaction in flight: no new request while a result is pending
  `TKST_ASSERT_NOW(a_busy_while_result, out_valid_i, !in_ready_i)

  `TKST_ASSERT_NEXT(a_accept_busy, in_valid_i && in_ready_i, !in_ready_i)

  // a rank or entry data only comes with a success status
  `TKST_ASSERT_NOW(a_data_means_ok, out_valid_i && (out_placed_i != '0 || out_score_i != '0 || out_label_i != '0), !out_status_i)

  `TKST_ASSERT_NOW(a_total_bound, out_valid_i, out_total_i <= TotalW'(LIST_DEPTH))

  `TKST_ASSERT_NEXT(a_result_holds, out_valid_i && !out_ready_i, out_valid_i && $stable(out_status_i) && $stable(out_total_i))

endmodule

bind top_k_score_table_core tkst_checker #(
  .LIST_DEPTH (LIST_DEPTH)
) u_tkst_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_placed_i (out_o.placed_rank),
  .out_score_i  (out_o.entry_score),
  .out_label_i  (out_o.entry_label),
  .out_total_i  (out_o.entry_total)
);
